// ----- design/heat_map_pyramid_splat_defines.svh -----
// ---------------------------------------------------------------------------
// Heat map pyramid splat: assertion macros
// Concurrent check macros, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef HEAT_MAP_PYRAMID_SPLAT_DEFINES_SVH
`define HEAT_MAP_PYRAMID_SPLAT_DEFINES_SVH

`ifndef SYNTH
`define HMPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heat map check failed");
`define HMPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heat map check failed");
`else
`define HMPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define HMPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/hmps_pkg.sv -----
// ---------------------------------------------------------------------------
// Heat map pyramid splat: package
// Payload types, controller states, command and status groups, constants.
// ---------------------------------------------------------------------------
package hmps_pkg;

    localparam int CNT_W    = 32;
    localparam int RADIUS_W = 7;
    localparam int RAD_W    = 8;
    localparam int OFS_W    = 9;
    localparam int COORD_W  = 11;
    localparam int WGT_W    = 9;

    localparam logic [CNT_W-1:0]    CNT_MAX      = '1;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 7'd20;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_SPLAT = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] row;
        logic [7:0] col;
    } t_in;

    typedef struct packed {
        logic [CNT_W-1:0] cell_value;
        logic [CNT_W-1:0] peak;
        logic             accepted;
    } t_out;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SPLAT,
        S_DRAIN1,
        S_DRAIN2,
        S_RD,
        S_RDWAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic zero_cell;
        logic zero_peak;
        logic clr_step;
        logic spl_step;
        logic rd_ctr;
        logic cap_cell;
        logic cap_peak;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       in_grid;
        logic       clr_last;
        logic       spl_last;
    } t_sts;

endpackage

// ----- design/heat_map_pyramid_splat.sv -----
// ---------------------------------------------------------------------------
// Heat map pyramid splat
// Grid of saturating heat counters with pyramid kernel splats and a peak.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel i_valid/o_ready carries op, row, col. Result channel
//   o_valid/i_ready returns cell_value, peak, accepted; one result per request.
//   Radius is written through i_cfg_we/i_cfg_wdata while the block is idle.
// Work per request, R = effective radius (1..MAX_RADIUS):
//   splat inside the grid: walks (2R+1)^2 kernel cells, one grid cell per cycle
//     through the single read port and single write port of the grid memory,
//     drains the write pipe, then reads the centre cell and updates the peak;
//   read inside the grid: reads the cell; request outside the grid: no grid access;
//   clear: sweeps all GRID_ROWS*GRID_COLS entries, one entry per cycle.
// One request is in work at a time; the next can be taken as soon as the
//   result sits in the output register, even while the receiver holds it off.
// Reset: the grid is swept to zero, all GRID_ROWS*GRID_COLS entries (65536 by
//   default), with o_ready low; peak clears and the radius returns to 20.
// Stall: a result waiting on i_ready holds its payload; a finished request
//   behind it waits inside the block until the output register frees up.
// ---------------------------------------------------------------------------
`include "heat_map_pyramid_splat_defines.svh"

module heat_map_pyramid_splat #(
    parameter int GRID_ROWS  = 256,
    parameter int GRID_COLS  = 256,
    parameter int MAX_RADIUS = 100
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hmps_pkg::RADIUS_W-1:0]   i_cfg_wdata,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  hmps_pkg::t_in                   i_data,
    output logic                            o_valid,
    input  logic                            i_ready,
    output hmps_pkg::t_out                  o_data
);

    hmps_pkg::t_cmd w_cmd;
    hmps_pkg::t_sts w_sts;

    hmps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    hmps_dp #(
        .GRID_ROWS  (GRID_ROWS),
        .GRID_COLS  (GRID_COLS),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_data      (i_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_data      (o_data)
    );

    `HMPS_ASSERT_IMPLY(a_load_free, i_clk, i_rst_n, w_cmd.load_out, !o_valid || i_ready)
    `HMPS_ASSERT_NEXT(a_one_req, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    `HMPS_ASSERT_IMPLY(a_port_excl, i_clk, i_rst_n, w_cmd.clr_step, !w_cmd.spl_step)
    `HMPS_ASSERT_IMPLY(a_outside_zero, i_clk, i_rst_n, o_valid && !o_data.accepted, o_data.cell_value == '0)

endmodule

// ----- design/hmps_ctrl.sv -----
// ---------------------------------------------------------------------------
// Heat map pyramid splat: controller
// Sequences clear sweeps, kernel walks, cell reads and result hand-off.
// ---------------------------------------------------------------------------
module hmps_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_ready,
    input  hmps_pkg::t_sts  i_sts,
    output hmps_pkg::t_cmd  o_cmd
);

    hmps_pkg::t_state r_state, n_state;
    logic r_clr_op, n_clr_op;
    logic r_out_valid, n_out_valid;
    logic w_out_free;

    assign w_out_free = !r_out_valid || i_ready;
    assign o_valid    = r_out_valid;
    assign o_ready    = (r_state == hmps_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hmps_pkg::S_CLEAR;
            r_clr_op    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_op    <= n_clr_op;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr_op    = r_clr_op;
        n_out_valid = r_out_valid;
        if (i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            hmps_pkg::S_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = r_clr_op ? hmps_pkg::S_OUT : hmps_pkg::S_IDLE;
                end
            end
            hmps_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = hmps_pkg::S_DECODE;
                end
            end
            hmps_pkg::S_DECODE: begin
                case (i_sts.op)
                    hmps_pkg::OP_CLEAR: begin
                        n_state  = hmps_pkg::S_CLEAR;
                        n_clr_op = 1'b1;
                    end
                    hmps_pkg::OP_SPLAT: begin
                        n_state = i_sts.in_grid ? hmps_pkg::S_SPLAT : hmps_pkg::S_OUT;
                    end
                    default: begin
                        n_state = i_sts.in_grid ? hmps_pkg::S_RD : hmps_pkg::S_OUT;
                    end
                endcase
            end
            hmps_pkg::S_SPLAT: begin
                if (i_sts.spl_last) begin
                    n_state = hmps_pkg::S_DRAIN1;
                end
            end
            hmps_pkg::S_DRAIN1: n_state = hmps_pkg::S_DRAIN2;
            hmps_pkg::S_DRAIN2: n_state = hmps_pkg::S_RD;
            hmps_pkg::S_RD:     n_state = hmps_pkg::S_RDWAIT;
            hmps_pkg::S_RDWAIT: n_state = hmps_pkg::S_OUT;
            hmps_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_state     = hmps_pkg::S_IDLE;
                    n_out_valid = 1'b1;
                    n_clr_op    = 1'b0;
                end
            end
            default: n_state = hmps_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            hmps_pkg::S_CLEAR: o_cmd.clr_step = 1'b1;
            hmps_pkg::S_IDLE:  o_cmd.start    = i_valid;
            hmps_pkg::S_DECODE: begin
                o_cmd.zero_cell = (i_sts.op == hmps_pkg::OP_CLEAR) || !i_sts.in_grid;
                o_cmd.zero_peak = (i_sts.op == hmps_pkg::OP_CLEAR);
            end
            hmps_pkg::S_SPLAT: o_cmd.spl_step = 1'b1;
            hmps_pkg::S_RD:    o_cmd.rd_ctr   = 1'b1;
            hmps_pkg::S_RDWAIT: begin
                o_cmd.cap_cell = 1'b1;
                o_cmd.cap_peak = (i_sts.op == hmps_pkg::OP_SPLAT);
            end
            hmps_pkg::S_OUT:   o_cmd.load_out = w_out_free;
            default:           o_cmd = '0;
        endcase
    end

endmodule

// ----- design/hmps_dp.sv -----
// ---------------------------------------------------------------------------
// Heat map pyramid splat: datapath
// Grid memory, kernel walk counters, read-modify-write pipe, peak, result.
// ---------------------------------------------------------------------------
module hmps_dp #(
    parameter int GRID_ROWS  = 256,
    parameter int GRID_COLS  = 256,
    parameter int MAX_RADIUS = 100
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hmps_pkg::RADIUS_W-1:0]   i_cfg_wdata,
    input  hmps_pkg::t_in                   i_data,
    input  hmps_pkg::t_cmd                  i_cmd,
    output hmps_pkg::t_sts                  o_sts,
    output hmps_pkg::t_out                  o_data
);

    localparam int DEPTH  = GRID_ROWS * GRID_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [hmps_pkg::CNT_W-1:0] r_mem [DEPTH];

    logic [hmps_pkg::RADIUS_W-1:0]      r_radius;
    logic [1:0]                         r_op;
    logic [7:0]                         r_row;
    logic [7:0]                         r_col;
    logic                               r_inside;
    logic [hmps_pkg::RAD_W-1:0]         r_rad;
    logic signed [hmps_pkg::OFS_W-1:0]  r_dr;
    logic signed [hmps_pkg::OFS_W-1:0]  r_dc;
    logic [ADDR_W-1:0]                  r_clr;
    logic                               r_a_v;
    logic [ADDR_W-1:0]                  r_a_addr;
    logic [hmps_pkg::WGT_W-1:0]         r_a_w;
    logic                               r_b_v;
    logic [ADDR_W-1:0]                  r_b_addr;
    logic [hmps_pkg::WGT_W-1:0]         r_b_w;
    logic [hmps_pkg::CNT_W-1:0]         r_rd_data;
    logic [ADDR_W-1:0]                  r_ctr_addr;
    logic [hmps_pkg::CNT_W-1:0]         r_cell;
    logic [hmps_pkg::CNT_W-1:0]         r_peak;
    hmps_pkg::t_out                     r_out;

    logic [hmps_pkg::RAD_W-1:0]           w_eff_rad;
    logic signed [hmps_pkg::OFS_W-1:0]    w_neg_eff;
    logic signed [hmps_pkg::OFS_W-1:0]    w_rad_s;
    logic signed [hmps_pkg::COORD_W-1:0]  w_cur_r;
    logic signed [hmps_pkg::COORD_W-1:0]  w_cur_c;
    logic [hmps_pkg::OFS_W-1:0]           w_abs_dr;
    logic [hmps_pkg::OFS_W-1:0]           w_abs_dc;
    logic [hmps_pkg::RAD_W-1:0]           w_dist;
    logic [hmps_pkg::WGT_W-1:0]           w_wgt;
    logic                                 w_in_grid;
    logic                                 w_in_inside;
    logic [ADDR_W-1:0]                    w_cur_addr;
    logic [ADDR_W-1:0]                    w_rd_addr;
    logic [hmps_pkg::CNT_W:0]             w_sum;
    logic [hmps_pkg::CNT_W-1:0]           w_sat;

    always_comb begin
        if (r_radius == '0) begin
            w_eff_rad = hmps_pkg::RAD_W'(1);
        end else if (32'(r_radius) > 32'(MAX_RADIUS)) begin
            w_eff_rad = hmps_pkg::RAD_W'(MAX_RADIUS);
        end else begin
            w_eff_rad = hmps_pkg::RAD_W'(r_radius);
        end
    end

    assign w_neg_eff = -$signed({1'b0, w_eff_rad});
    assign w_rad_s   = $signed({1'b0, r_rad});

    assign w_in_inside = (32'(i_data.row) < 32'(GRID_ROWS))
                      && (32'(i_data.col) < 32'(GRID_COLS));

    assign w_cur_r = $signed({{(hmps_pkg::COORD_W-8){1'b0}}, r_row})
                   + hmps_pkg::COORD_W'(r_dr);
    assign w_cur_c = $signed({{(hmps_pkg::COORD_W-8){1'b0}}, r_col})
                   + hmps_pkg::COORD_W'(r_dc);

    assign w_abs_dr = r_dr[hmps_pkg::OFS_W-1] ? unsigned'(-r_dr) : unsigned'(r_dr);
    assign w_abs_dc = r_dc[hmps_pkg::OFS_W-1] ? unsigned'(-r_dc) : unsigned'(r_dc);
    assign w_dist   = (w_abs_dr > w_abs_dc) ? w_abs_dr[hmps_pkg::RAD_W-1:0]
                                            : w_abs_dc[hmps_pkg::RAD_W-1:0];
    assign w_wgt    = {1'b0, r_rad} + hmps_pkg::WGT_W'(1) - {1'b0, w_dist};

    assign w_in_grid = !w_cur_r[hmps_pkg::COORD_W-1] && !w_cur_c[hmps_pkg::COORD_W-1]
                    && (32'(unsigned'(w_cur_r)) < 32'(GRID_ROWS))
                    && (32'(unsigned'(w_cur_c)) < 32'(GRID_COLS));

    assign w_cur_addr = ADDR_W'(32'(unsigned'(w_cur_r)) * 32'(GRID_COLS)
                              + 32'(unsigned'(w_cur_c)));

    assign w_rd_addr = i_cmd.rd_ctr ? r_ctr_addr : r_a_addr;

    assign w_sum = {1'b0, r_rd_data} + (hmps_pkg::CNT_W + 1)'(r_b_w);
    assign w_sat = w_sum[hmps_pkg::CNT_W] ? hmps_pkg::CNT_MAX
                                         : w_sum[hmps_pkg::CNT_W-1:0];

    // grid memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_mem[r_clr] <= '0;
        end else if (r_b_v) begin
            r_mem[r_b_addr] <= w_sat;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= hmps_pkg::RADIUS_RESET;
            r_clr    <= '0;
            r_a_v    <= 1'b0;
            r_b_v    <= 1'b0;
            r_peak   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_radius <= i_cfg_wdata;
            end
            if (i_cmd.clr_step) begin
                r_clr <= o_sts.clr_last ? '0 : r_clr + ADDR_W'(1);
            end
            r_a_v <= i_cmd.spl_step && w_in_grid;
            r_b_v <= r_a_v;
            if (i_cmd.zero_peak) begin
                r_peak <= '0;
            end else if (i_cmd.cap_peak && (r_rd_data > r_peak)) begin
                r_peak <= r_rd_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op     <= i_data.op;
            r_row    <= i_data.row;
            r_col    <= i_data.col;
            r_inside <= w_in_inside;
            r_rad    <= w_eff_rad;
            r_dr     <= w_neg_eff;
            r_dc     <= w_neg_eff;
        end else if (i_cmd.spl_step) begin
            if (r_dc == w_rad_s) begin
                r_dc <= -w_rad_s;
                r_dr <= r_dr + hmps_pkg::OFS_W'(1);
            end else begin
                r_dc <= r_dc + hmps_pkg::OFS_W'(1);
            end
        end
        r_a_addr   <= w_cur_addr;
        r_a_w      <= w_wgt;
        r_b_addr   <= r_a_addr;
        r_b_w      <= r_a_w;
        r_ctr_addr <= ADDR_W'(32'(r_row) * 32'(GRID_COLS) + 32'(r_col));
        if (i_cmd.zero_cell) begin
            r_cell <= '0;
        end else if (i_cmd.cap_cell) begin
            r_cell <= r_rd_data;
        end
        if (i_cmd.load_out) begin
            r_out.cell_value <= r_cell;
            r_out.peak       <= r_peak;
            r_out.accepted   <= r_inside;
        end
    end

    assign o_sts.op       = r_op;
    assign o_sts.in_grid  = r_inside;
    assign o_sts.clr_last = (r_clr == ADDR_W'(DEPTH - 1));
    assign o_sts.spl_last = (r_dr == w_rad_s) && (r_dc == w_rad_s);
    assign o_data         = r_out;

endmodule
